// ===== sv/vrld_pkg.sv =====
// Package with shared widths and the byte classification type of the record log decoder.
`timescale 1ns / 1ps

package vrld_pkg;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 56;
    localparam int TYPE_W  = 2;
    localparam int INDEX_W = 2;

    localparam logic [BYTE_W-1:0] LEAD_BIAS = 8'd8;

    localparam logic [TYPE_W-1:0] REC_ATOM   = 2'd0;
    localparam logic [TYPE_W-1:0] REC_CREATE = 2'd1;
    localparam logic [TYPE_W-1:0] REC_REMOVE = 2'd2;

    localparam logic [BYTE_W-1:0] CMD_ATOM   = 8'd1;
    localparam logic [BYTE_W-1:0] CMD_CREATE = 8'd2;
    localparam logic [BYTE_W-1:0] CMD_REMOVE = 8'd3;

    typedef struct packed {
        logic cmd_known;
        logic lead_short;
        logic lead_zero;
    } vrld_class_t;

endpackage

// ===== sv/varint_record_log_decoder.sv =====
// Top level of the length-prefixed varint record log decoder.
`timescale 1ns / 1ps

// The block takes a change log one byte per request on the data channel
// (data_byte, data_valid, data_ready) and delivers decoded results on the
// result channel (result_valid, result_ready and the result fields).
// Each byte is classified on entry and held in a two-entry queue; the
// parser behind it takes one byte from the queue per cycle while its output
// register is free or being emptied, and writes any result into it.
// Throughput is one byte per cycle while the receiver takes each result,
// set by the parser state and the output register updating once per byte;
// the output register frees whenever the receiver takes its result.
// Without stalls the byte that completes a result passes through a queue
// entry and then the output register, where the receiver can take it.
// Bytes that complete nothing, such as command bytes and the first bytes of
// a multi-byte number, produce no result but still pass through the parser.
// When the receiver stalls, the output register holds its result, the queue
// fills, and data_ready falls once both entries are occupied.
// Reset empties the queue, drops any pending result and returns the parser
// to expecting a command byte.

module varint_record_log_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [vrld_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          data_valid,
    output logic                          data_ready,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [vrld_pkg::TYPE_W-1:0]   record_type,
    output logic [vrld_pkg::INDEX_W-1:0]  field_index,
    output logic [vrld_pkg::VALUE_W-1:0]  value,
    output logic                          is_text_byte,
    output logic                          record_end,
    output logic                          bad_command
);

    logic                        q_valid;
    logic [vrld_pkg::BYTE_W-1:0] q_byte;
    vrld_pkg::vrld_class_t       q_class;
    logic                        q_pop;

    vrld_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .data_valid (data_valid),
        .data_ready (data_ready),
        .q_valid    (q_valid),
        .q_byte     (q_byte),
        .q_class    (q_class),
        .q_pop      (q_pop)
    );

    vrld_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_byte       (q_byte),
        .q_class      (q_class),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .record_type  (record_type),
        .field_index  (field_index),
        .value        (value),
        .is_text_byte (is_text_byte),
        .record_end   (record_end),
        .bad_command  (bad_command)
    );

endmodule

// ===== sv/vrld_front.sv =====
// Input stage: accepts raw bytes, classifies them and holds them in a two-entry queue.
`timescale 1ns / 1ps

module vrld_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [vrld_pkg::BYTE_W-1:0]  data_byte,
    input  logic                         data_valid,
    output logic                         data_ready,
    output logic                         q_valid,
    output logic [vrld_pkg::BYTE_W-1:0]  q_byte,
    output vrld_pkg::vrld_class_t        q_class,
    input  logic                         q_pop
);

    logic [vrld_pkg::BYTE_W-1:0] byte_reg [2];
    vrld_pkg::vrld_class_t       class_reg [2];
    logic                        wr_ptr_reg;
    logic                        wr_ptr_next;
    logic                        rd_ptr_reg;
    logic                        rd_ptr_next;
    logic [1:0]                  count_reg;
    logic [1:0]                  count_next;
    logic                        push;
    logic                        pop;
    vrld_pkg::vrld_class_t       class_in;

    always_comb
    begin
        class_in.cmd_known  = (data_byte == vrld_pkg::CMD_ATOM)
                           || (data_byte == vrld_pkg::CMD_CREATE)
                           || (data_byte == vrld_pkg::CMD_REMOVE);
        class_in.lead_short = (data_byte < vrld_pkg::LEAD_BIAS);
        class_in.lead_zero  = (data_byte == '0);
    end

    assign data_ready = (count_reg != 2'd2);
    assign push       = data_valid && data_ready;
    assign q_valid    = (count_reg != 2'd0);
    assign pop        = q_pop && q_valid;
    assign q_byte     = byte_reg[rd_ptr_reg];
    assign q_class    = class_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            byte_reg[wr_ptr_reg]  <= data_byte;
            class_reg[wr_ptr_reg] <= class_in;
        end
    end

endmodule

// ===== sv/vrld_back.sv =====
// Parser stage: runs the record state machine on queued bytes and registers each result.
`timescale 1ns / 1ps

module vrld_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  logic [vrld_pkg::BYTE_W-1:0]   q_byte,
    input  vrld_pkg::vrld_class_t         q_class,
    output logic                          q_pop,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [vrld_pkg::TYPE_W-1:0]   record_type,
    output logic [vrld_pkg::INDEX_W-1:0]  field_index,
    output logic [vrld_pkg::VALUE_W-1:0]  value,
    output logic                          is_text_byte,
    output logic                          record_end,
    output logic                          bad_command
);

    localparam logic [1:0] PH_CMD  = 2'd0;
    localparam logic [1:0] PH_LEAD = 2'd1;
    localparam logic [1:0] PH_MORE = 2'd2;
    localparam logic [1:0] PH_TEXT = 2'd3;

    logic [1:0]                         phase_reg;
    logic [1:0]                         phase_next;
    logic [vrld_pkg::TYPE_W-1:0]        rtype_reg;
    logic [vrld_pkg::TYPE_W-1:0]        rtype_next;
    logic [vrld_pkg::INDEX_W-1:0]       fcount_reg;
    logic [vrld_pkg::INDEX_W-1:0]       fcount_next;
    logic [2:0]                         left_reg;
    logic [2:0]                         left_next;
    logic [2:0]                         pos_reg;
    logic [2:0]                         pos_next;
    logic [vrld_pkg::VALUE_W-1:0]       acc_reg;
    logic [vrld_pkg::VALUE_W-1:0]       acc_next;
    logic [vrld_pkg::VALUE_W-1:0]       text_left_reg;
    logic [vrld_pkg::VALUE_W-1:0]       text_left_next;
    logic [vrld_pkg::VALUE_W-1:0]       acc_merged;

    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [vrld_pkg::TYPE_W-1:0]        out_type_reg;
    logic [vrld_pkg::INDEX_W-1:0]       out_index_reg;
    logic [vrld_pkg::VALUE_W-1:0]       out_value_reg;
    logic                               out_text_reg;
    logic                               out_end_reg;
    logic                               out_bad_reg;

    logic                               emit;
    logic [vrld_pkg::TYPE_W-1:0]        e_type;
    logic [vrld_pkg::INDEX_W-1:0]       e_index;
    logic [vrld_pkg::VALUE_W-1:0]       e_value;
    logic                               e_text;
    logic                               e_end;
    logic                               e_bad;
    logic                               fin;
    logic [vrld_pkg::VALUE_W-1:0]       fin_val;
    logic [vrld_pkg::INDEX_W-1:0]       last_index;

    assign q_pop = q_valid && (!out_valid_reg || result_ready);

    assign acc_merged = acc_reg
                      | ({{(vrld_pkg::VALUE_W-vrld_pkg::BYTE_W){1'b0}}, q_byte}
                         << {pos_reg, 3'b000});

    always_comb
    begin
        phase_next     = phase_reg;
        rtype_next     = rtype_reg;
        fcount_next    = fcount_reg;
        left_next      = left_reg;
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        text_left_next = text_left_reg;
        emit           = 1'b0;
        e_type         = vrld_pkg::REC_ATOM;
        e_index        = '0;
        e_value        = {{(vrld_pkg::VALUE_W-vrld_pkg::BYTE_W){1'b0}}, q_byte};
        e_text         = 1'b0;
        e_end          = 1'b0;
        e_bad          = 1'b0;
        fin            = 1'b0;
        fin_val        = '0;
        last_index     = (rtype_reg == vrld_pkg::REC_CREATE) ? 2'd3 : 2'd1;

        unique case (phase_reg)
            PH_CMD:
            begin
                if (q_class.cmd_known)
                begin
                    rtype_next  = q_byte[vrld_pkg::TYPE_W-1:0] - 2'd1;
                    fcount_next = '0;
                    phase_next  = PH_LEAD;
                end
                else
                begin
                    emit  = 1'b1;
                    e_end = 1'b1;
                    e_bad = 1'b1;
                end
            end
            PH_LEAD:
            begin
                if (!q_class.lead_short)
                begin
                    fin     = 1'b1;
                    fin_val = {{(vrld_pkg::VALUE_W-vrld_pkg::BYTE_W){1'b0}},
                               q_byte - vrld_pkg::LEAD_BIAS};
                end
                else if (q_class.lead_zero)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    left_next  = q_byte[2:0];
                    pos_next   = '0;
                    acc_next   = '0;
                    phase_next = PH_MORE;
                end
            end
            PH_MORE:
            begin
                acc_next  = acc_merged;
                pos_next  = pos_reg + 3'd1;
                left_next = left_reg - 3'd1;
                if (left_reg == 3'd1)
                begin
                    fin     = 1'b1;
                    fin_val = acc_merged;
                end
            end
            PH_TEXT:
            begin
                text_left_next = text_left_reg - 1'b1;
                emit           = 1'b1;
                e_text         = 1'b1;
                if (text_left_reg == {{(vrld_pkg::VALUE_W-1){1'b0}}, 1'b1})
                begin
                    e_end      = 1'b1;
                    phase_next = PH_CMD;
                end
            end
            default:
            begin
                phase_next = PH_CMD;
            end
        endcase

        if (fin)
        begin
            emit     = 1'b1;
            e_type   = rtype_reg;
            e_index  = fcount_reg;
            e_value  = fin_val;
            acc_next = '0;
            pos_next = '0;
            left_next = '0;
            if (rtype_reg == vrld_pkg::REC_ATOM)
            begin
                if (fin_val == '0)
                begin
                    e_end      = 1'b1;
                    phase_next = PH_CMD;
                end
                else
                begin
                    text_left_next = fin_val;
                    phase_next     = PH_TEXT;
                end
            end
            else if (fcount_reg >= last_index)
            begin
                e_end      = 1'b1;
                phase_next = PH_CMD;
            end
            else
            begin
                fcount_next = fcount_reg + 2'd1;
                phase_next  = PH_LEAD;
            end
        end

        if (q_pop && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_CMD;
            rtype_reg     <= vrld_pkg::REC_ATOM;
            fcount_reg    <= '0;
            left_reg      <= '0;
            pos_reg       <= '0;
            acc_reg       <= '0;
            text_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg     <= phase_next;
                rtype_reg     <= rtype_next;
                fcount_reg    <= fcount_next;
                left_reg      <= left_next;
                pos_reg       <= pos_next;
                acc_reg       <= acc_next;
                text_left_reg <= text_left_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && emit)
        begin
            out_type_reg  <= e_type;
            out_index_reg <= e_index;
            out_value_reg <= e_value;
            out_text_reg  <= e_text;
            out_end_reg   <= e_end;
            out_bad_reg   <= e_bad;
        end
    end

    assign result_valid = out_valid_reg;
    assign record_type  = out_type_reg;
    assign field_index  = out_index_reg;
    assign value        = out_value_reg;
    assign is_text_byte = out_text_reg;
    assign record_end   = out_end_reg;
    assign bad_command  = out_bad_reg;

endmodule
